[hw/rtl/tks_pkg.sv]
package tks_pkg;

   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int SCALE_W = 10;
   localparam int HOLD_W  = 16;
   localparam int PRESS_W = 8;
   localparam int UNITS_W = 6;
   localparam int DELAY_W = UNITS_W + SCALE_W;

   localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(218);
   localparam logic [HOLD_W-1:0]  HOLD_RST  = HOLD_W'(5);
   localparam logic [PRESS_W-1:0] PRESS_RST = PRESS_W'(1);

   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_SCALE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_WAIT   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TICKS = CSR_IDX_W'(2);

   localparam int KEY_W    = 6;
   localparam int KEY_HOLD  = 0;
   localparam int KEY_TWO   = 1;
   localparam int KEY_FOUR  = 2;
   localparam int KEY_ZERO  = 3;
   localparam int KEY_ENTER = 4;
   localparam int KEY_HIT   = 5;

   localparam logic [2:0] ROUND_HIT  = 3'd3;
   localparam logic [2:0] ROUND_LAST = 3'd7;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_DELAY     = 4'd1,
      PH_PREHOLD   = 4'd2,
      PH_HOLD_DN   = 4'd3,
      PH_TWO_GAP   = 4'd4,
      PH_TWO_DN    = 4'd5,
      PH_FOUR_GAP  = 4'd6,
      PH_FOUR_DN   = 4'd7,
      PH_ZERO_GAP  = 4'd8,
      PH_ZERO_DN   = 4'd9,
      PH_ENTER_GAP = 4'd10,
      PH_ENTER_DN  = 4'd11,
      PH_HIT_WAIT  = 4'd12,
      PH_HIT_DN    = 4'd13,
      PH_DONE      = 4'd14
   } phase_type;

   // clamp to the counter range
   function automatic logic [COUNT_BITS-1:0] sat_count(input logic [32:0] v);
      logic [COUNT_BITS-1:0] r;
      if (v > 33'(COUNT_MAX)) begin
         r = COUNT_MAX;
      end else begin
         r = v[COUNT_BITS-1:0];
      end
      return r;
   endfunction

endpackage

[hw/rtl/timed_keypress_sequencer_unit.sv]
// channel | direction | ports                                   | handshake
// req     | in        | timer_tick, start_switch, delay_switches | req_valid / req_stall
// rsp     | out       | key_lines, phase, round_count, done_res  | rsp_valid / rsp_stall
// csr     | in        | index, data (write only)                | csr_valid / csr_ready
//
// One word per cycle while req_stall is low: the sequencer state updates in the cycle a word is taken,
// and its result lands in the output register at the same edge.
// rsp_valid rises in the cycle after a req word is accepted.
// req_stall follows rsp_stall only while the output register holds a word.
// reset (synchronous) returns to idle, clears counters and keys, reloads registers.
// csr_ready is always high; index 3 is ignored.
module timed_keypress_sequencer_unit
   import tks_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_timer_tick,
   input  logic                  req_start_switch,
   input  logic [4:0]            req_delay_switches,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KEY_W-1:0]      rsp_key_lines,
   output logic [3:0]            rsp_phase,
   output logic [2:0]            rsp_round_count,
   output logic                  rsp_done_res,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [SCALE_W-1:0]    scale_ff;
   logic [HOLD_W-1:0]     hold_ff;
   logic [PRESS_W-1:0]    press_ff;

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0] lim_ff, lim_in;
   logic [2:0]            rounds_ff, rounds_in;
   logic [KEY_W-1:0]      keys_ff, keys_in;

   logic                  rsp_valid_ff;
   logic [KEY_W-1:0]      rsp_keys_ff;
   logic [3:0]            rsp_phase_ff;
   logic [2:0]            rsp_rounds_ff;
   logic                  rsp_done_ff;

   logic                  accept;
   logic [UNITS_W-1:0]    units;
   logic [DELAY_W-1:0]    delay;
   logic [COUNT_BITS-1:0] delay_sat;
   logic [COUNT_BITS-1:0] hold_sat;
   logic [COUNT_BITS-1:0] press_sat;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [COUNT_BITS-1:0] cur_lim;
   logic [2:0]            round_nxt;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // switch bits weigh 32..2, i.e. twice the switch value
   assign units     = {req_delay_switches, 1'b0};
   assign delay     = DELAY_W'(units) * DELAY_W'(scale_ff);
   assign delay_sat = sat_count(33'(delay));
   assign hold_sat  = sat_count(33'(hold_ff));
   assign press_sat = sat_count(33'(press_ff));
   assign cnt_inc   = sat_count(33'(cnt_ff) + 33'(req_timer_tick));
   assign cur_lim   = (phase_ff == PH_DELAY) ? delay_sat : lim_ff;
   assign round_nxt = rounds_ff + 3'd1;

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      lim_in    = lim_ff;
      rounds_in = rounds_ff;
      keys_in   = keys_ff;
      if (phase_ff == PH_IDLE || phase_ff > PH_DONE) begin
         phase_in = PH_IDLE;
         if (req_start_switch) begin
            phase_in  = PH_DELAY;
            cnt_in    = '0;
            lim_in    = delay_sat;
            rounds_in = '0;
            keys_in   = '0;
         end
      end else if (!req_start_switch) begin
         phase_in = PH_IDLE;
         cnt_in   = '0;
         keys_in  = '0;
      end else begin
         cnt_in = cnt_inc;
         if (phase_ff == PH_DELAY) begin
            lim_in = delay_sat;
         end
         if (phase_ff != PH_DONE && cnt_inc > cur_lim) begin
            cnt_in = '0;
            lim_in = press_sat;
            case (phase_ff)
               PH_DELAY: begin
                  phase_in = PH_PREHOLD;
                  lim_in   = hold_sat;
               end
               PH_PREHOLD: begin
                  keys_in[KEY_HOLD] = 1'b1;
                  phase_in = PH_HOLD_DN;
               end
               PH_HOLD_DN: begin
                  keys_in[KEY_HOLD] = 1'b0;
                  phase_in = PH_TWO_GAP;
               end
               PH_TWO_GAP: begin
                  keys_in[KEY_TWO] = 1'b1;
                  phase_in = PH_TWO_DN;
               end
               PH_TWO_DN: begin
                  keys_in[KEY_TWO] = 1'b0;
                  phase_in = PH_FOUR_GAP;
               end
               PH_FOUR_GAP: begin
                  keys_in[KEY_FOUR] = 1'b1;
                  phase_in = PH_FOUR_DN;
               end
               PH_FOUR_DN: begin
                  keys_in[KEY_FOUR] = 1'b0;
                  phase_in = PH_ZERO_GAP;
               end
               PH_ZERO_GAP: begin
                  keys_in[KEY_ZERO] = 1'b1;
                  phase_in = PH_ZERO_DN;
               end
               PH_ZERO_DN: begin
                  keys_in[KEY_ZERO] = 1'b0;
                  phase_in = PH_ENTER_GAP;
               end
               PH_ENTER_GAP: begin
                  keys_in[KEY_ENTER] = 1'b1;
                  phase_in = PH_ENTER_DN;
               end
               PH_ENTER_DN: begin
                  keys_in[KEY_ENTER] = 1'b0;
                  rounds_in = round_nxt;
                  if (round_nxt == ROUND_HIT) begin
                     phase_in = PH_HIT_WAIT;
                  end else if (round_nxt == ROUND_LAST) begin
                     phase_in = PH_DONE;
                     lim_in   = '0;
                  end else begin
                     phase_in = PH_DELAY;
                     lim_in   = delay_sat;
                  end
               end
               PH_HIT_WAIT: begin
                  keys_in[KEY_HIT] = 1'b1;
                  phase_in = PH_HIT_DN;
               end
               PH_HIT_DN: begin
                  // straight into key 2 of the next round
                  keys_in[KEY_HIT] = 1'b0;
                  phase_in = PH_TWO_GAP;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RST;
         hold_ff  <= HOLD_RST;
         press_ff <= PRESS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELAY_SCALE: scale_ff <= csr_data[SCALE_W-1:0];
            CSR_HOLD_WAIT:   hold_ff  <= csr_data[HOLD_W-1:0];
            CSR_PRESS_TICKS: press_ff <= csr_data[PRESS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         lim_ff       <= '0;
         rounds_ff    <= '0;
         keys_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            cnt_ff    <= cnt_in;
            lim_ff    <= lim_in;
            rounds_ff <= rounds_in;
            keys_ff   <= keys_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_keys_ff   <= keys_in;
         rsp_phase_ff  <= phase_in;
         rsp_rounds_ff <= rounds_in;
         rsp_done_ff   <= (phase_in == PH_DONE);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_lines   = rsp_keys_ff;
   assign rsp_phase       = rsp_phase_ff;
   assign rsp_round_count = rsp_rounds_ff;
   assign rsp_done_res    = rsp_done_ff;

endmodule

[hw/rtl/tks_checker.sv]
module tks_assertions
   import tks_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [KEY_W-1:0]      rsp_key_lines,
   input logic [3:0]            rsp_phase,
   input logic                  rsp_done_res
);

   // input side only backs up when a result word is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a held result");

   a_done_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_done_res == (rsp_phase == PH_DONE)))
      else $error("done_res disagrees with phase");

   // idle and done never hold a key down
   a_keys_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_phase == PH_IDLE || rsp_phase == PH_DONE)) |-> (rsp_key_lines == '0))
      else $error("key pressed in idle or done");

   a_word_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_key_lines) && $stable(rsp_phase)))
      else $error("stalled result word changed");

endmodule

bind timed_keypress_sequencer_unit tks_assertions u_tks_checker (.*);
